// ----- rtl/segint_pkg.sv -----
// ----------------------------------------------------------------------------
// segint_pkg: shared types and constants for the segment intersection test
// Holds the fixed output format, the parameter search widths and the
// request tag that travels beside the arithmetic down the pipeline.
// ----------------------------------------------------------------------------
package segint_pkg;

	// Quotient bits of |v|^2 * 2^32 / |c|^2 that are kept before saturation.
	localparam int QW = 63;
	// Magnitude bits of t and u (saturates at 2^31 - 1).
	localparam int MW = 31;
	// Q16.16 squared: the numerator is shifted by twice the fraction bits.
	localparam int PSHIFT = 32;
	// Output and register widths.
	localparam int OUT_W = 32;
	localparam int EPSP_W = 32;
	localparam int EPS_W = 16;
	localparam int EPSQ_W = 64;
	// 1.0 in Q16.16.
	localparam int ONE_Q16 = 65536;

	typedef enum logic [0:0] {
		CFG_EPS_PARALLEL = 1'b0,
		CFG_EPS_PARAM    = 1'b1
	} cfg_idx_t;

	// Per-request flags that ride alongside the divider and root pipelines.
	typedef struct packed {
		logic par;
		logic t_pos;
		logic u_pos;
	} tag_t;

endpackage

// ----- rtl/segint_geom.sv -----
// ----------------------------------------------------------------------------
// segint_geom: cross products, squared norms, signs and parallel test
// Six register stages: products, cross vectors, squares and dot terms,
// sums, then the parallel compare and sign flags.
// ----------------------------------------------------------------------------
module segint_geom #(
	parameter int W = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic signed [W-1:0]               p [0:2],
	input  logic signed [W-1:0]               r [0:2],
	input  logic signed [W-1:0]               q [0:2],
	input  logic signed [W-1:0]               s [0:2],
	input  logic [segint_pkg::EPSQ_W-1:0]     eps_sq,
	output logic                              out_vld,
	output logic [4*W+1:0]                    nc,
	output logic [4*W+3:0]                    ntv,
	output logic [4*W+3:0]                    nuv,
	output segint_pkg::tag_t                  tag
);

	localparam int PW   = 2 * W;
	localparam int CW   = 2 * W + 1;
	localparam int DPW  = 2 * W + 1;
	localparam int VW   = 2 * W + 2;
	localparam int NCW  = 4 * W + 2;
	localparam int NVW  = 4 * W + 4;
	localparam int DTPW = CW + VW;
	localparam int DTW  = CW + VW + 2;
	localparam int FRAC = W / 2;
	localparam int SHE  = 4 * FRAC;
	localparam int CMPW = (NCW + segint_pkg::PSHIFT > segint_pkg::EPSQ_W + SHE) ?
		NCW + segint_pkg::PSHIFT : segint_pkg::EPSQ_W + SHE;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [PW-1:0]   prc_s1 [0:5];
	logic signed [W:0]      d_s1 [0:2];
	logic signed [W-1:0]    r_s1 [0:2];
	logic signed [W-1:0]    s_s1 [0:2];
	logic signed [CW-1:0]   c_s2 [0:2];
	logic signed [DPW-1:0]  dsp_s2 [0:5];
	logic signed [DPW-1:0]  drp_s2 [0:5];
	logic signed [CW-1:0]   c_s3 [0:2];
	logic signed [VW-1:0]   tv_s3 [0:2];
	logic signed [VW-1:0]   uv_s3 [0:2];
	logic [2*CW-1:0]        csq_s4 [0:2];
	logic [2*VW-1:0]        tsq_s4 [0:2];
	logic [2*VW-1:0]        usq_s4 [0:2];
	logic signed [DTPW-1:0] tdot_s4 [0:2];
	logic signed [DTPW-1:0] udot_s4 [0:2];
	logic [NCW-1:0]         nc_s5;
	logic [NVW-1:0]         ntv_s5;
	logic [NVW-1:0]         nuv_s5;
	logic signed [DTW-1:0]  tdot_s5;
	logic signed [DTW-1:0]  udot_s5;
	logic [NCW-1:0]         nc_s6;
	logic [NVW-1:0]         ntv_s6;
	logic [NVW-1:0]         nuv_s6;
	segint_pkg::tag_t       tag_s6;
	logic [CMPW-1:0]        par_lhs;
	logic [CMPW-1:0]        par_rhs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign par_lhs = CMPW'(nc_s5) << segint_pkg::PSHIFT;
	assign par_rhs = CMPW'(eps_sq) << SHE;

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: the six products of r x s and the offset q - p.
			prc_s1[0] <= r[1] * s[2];
			prc_s1[1] <= r[2] * s[1];
			prc_s1[2] <= r[2] * s[0];
			prc_s1[3] <= r[0] * s[2];
			prc_s1[4] <= r[0] * s[1];
			prc_s1[5] <= r[1] * s[0];
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= (W+1)'(q[i]) - (W+1)'(p[i]);
				r_s1[i] <= r[i];
				s_s1[i] <= s[i];
			end
			// Stage 2: c = r x s and the products of d x s and d x r.
			c_s2[0] <= CW'(prc_s1[0]) - CW'(prc_s1[1]);
			c_s2[1] <= CW'(prc_s1[2]) - CW'(prc_s1[3]);
			c_s2[2] <= CW'(prc_s1[4]) - CW'(prc_s1[5]);
			dsp_s2[0] <= d_s1[1] * s_s1[2];
			dsp_s2[1] <= d_s1[2] * s_s1[1];
			dsp_s2[2] <= d_s1[2] * s_s1[0];
			dsp_s2[3] <= d_s1[0] * s_s1[2];
			dsp_s2[4] <= d_s1[0] * s_s1[1];
			dsp_s2[5] <= d_s1[1] * s_s1[0];
			drp_s2[0] <= d_s1[1] * r_s1[2];
			drp_s2[1] <= d_s1[2] * r_s1[1];
			drp_s2[2] <= d_s1[2] * r_s1[0];
			drp_s2[3] <= d_s1[0] * r_s1[2];
			drp_s2[4] <= d_s1[0] * r_s1[1];
			drp_s2[5] <= d_s1[1] * r_s1[0];
			// Stage 3: the two cross vectors.
			for (int i = 0; i < 3; i++) begin
				c_s3[i]  <= c_s2[i];
				tv_s3[i] <= VW'(dsp_s2[2*i]) - VW'(dsp_s2[2*i+1]);
				uv_s3[i] <= VW'(drp_s2[2*i]) - VW'(drp_s2[2*i+1]);
			end
			// Stage 4: squares and dot-product terms.
			for (int i = 0; i < 3; i++) begin
				csq_s4[i]  <= c_s3[i] * c_s3[i];
				tsq_s4[i]  <= tv_s3[i] * tv_s3[i];
				usq_s4[i]  <= uv_s3[i] * uv_s3[i];
				tdot_s4[i] <= tv_s3[i] * c_s3[i];
				udot_s4[i] <= uv_s3[i] * c_s3[i];
			end
			// Stage 5: sums.
			nc_s5   <= NCW'(csq_s4[0]) + NCW'(csq_s4[1]) + NCW'(csq_s4[2]);
			ntv_s5  <= NVW'(tsq_s4[0]) + NVW'(tsq_s4[1]) + NVW'(tsq_s4[2]);
			nuv_s5  <= NVW'(usq_s4[0]) + NVW'(usq_s4[1]) + NVW'(usq_s4[2]);
			tdot_s5 <= DTW'(tdot_s4[0]) + DTW'(tdot_s4[1]) + DTW'(tdot_s4[2]);
			udot_s5 <= DTW'(udot_s4[0]) + DTW'(udot_s4[1]) + DTW'(udot_s4[2]);
			// Stage 6: parallel test and the signs of t and u.
			nc_s6        <= nc_s5;
			ntv_s6       <= ntv_s5;
			nuv_s6       <= nuv_s5;
			tag_s6.par   <= par_lhs <= par_rhs;
			tag_s6.t_pos <= !tdot_s5[DTW-1] && (tdot_s5 != '0);
			tag_s6.u_pos <= !udot_s5[DTW-1] && (udot_s5 != '0);
		end
	end

	assign out_vld = vld_s6;
	assign nc      = nc_s6;
	assign ntv     = ntv_s6;
	assign nuv     = nuv_s6;
	assign tag     = tag_s6;

endmodule

// ----- rtl/segint_div.sv -----
// ----------------------------------------------------------------------------
// segint_div: two-lane pipelined restoring divider
// Computes floor(num * 2^32 / den) for two numerators over a shared
// divisor, one quotient bit per stage, saturating to all ones on overflow.
// ----------------------------------------------------------------------------
module segint_div #(
	parameter int NW = 68,
	parameter int DW = 66
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [DW-1:0]               den,
	input  logic [NW-1:0]               num_t,
	input  logic [NW-1:0]               num_u,
	input  segint_pkg::tag_t            tag_i,
	output logic                        out_vld,
	output logic [segint_pkg::QW-1:0]   q_t,
	output logic [segint_pkg::QW-1:0]   q_u,
	output segint_pkg::tag_t            tag_o
);

	localparam int QW  = segint_pkg::QW;
	localparam int NLB = segint_pkg::QW - segint_pkg::PSHIFT;

	logic [NW-1:0]    num [0:1];
	logic             vld_s [0:QW];
	logic [DW-1:0]    den_s [0:QW];
	segint_pkg::tag_t tag_s [0:QW];
	logic [DW-1:0]    rem_s [0:1][0:QW];
	logic [QW-1:0]    nl_s  [0:1][0:QW];
	logic [QW-1:0]    q_s   [0:1][0:QW];
	logic             ovf_s [0:1][0:QW];

	assign num = '{num_t, num_u};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			tag_s[0] <= tag_i;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		// The bits above the quotient window decide overflow up front.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[l][0] <= DW'(num[l] >> NLB);
				ovf_s[l][0] <= (num[l] >> NLB) >= NW'(den);
				nl_s[l][0]  <= {num[l][NLB-1:0], {segint_pkg::PSHIFT{1'b0}}};
				q_s[l][0]   <= '0;
			end
		end

		for (genvar k = 1; k <= QW; k++) begin : g_bit
			logic [DW:0] sh;
			logic        ge;

			assign sh = {rem_s[l][k-1], nl_s[l][k-1][QW-1]};
			assign ge = sh >= {1'b0, den_s[k-1]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k] <= ge ? DW'(sh - {1'b0, den_s[k-1]}) : DW'(sh);
					nl_s[l][k]  <= {nl_s[l][k-1][QW-2:0], 1'b0};
					q_s[l][k]   <= {q_s[l][k-1][QW-2:0], ge};
					ovf_s[l][k] <= ovf_s[l][k-1];
				end
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign tag_o   = tag_s[QW];
	assign q_t     = ovf_s[0][QW] ? {QW{1'b1}} : q_s[0][QW];
	assign q_u     = ovf_s[1][QW] ? {QW{1'b1}} : q_s[1][QW];

endmodule

// ----- rtl/segint_isqrt.sv -----
// ----------------------------------------------------------------------------
// segint_isqrt: two-lane pipelined integer square root
// One result bit per stage from the top down, keeping the remainder
// Q - m^2, so each stage is a single compare and subtract.
// ----------------------------------------------------------------------------
module segint_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [segint_pkg::QW-1:0]   q_t,
	input  logic [segint_pkg::QW-1:0]   q_u,
	input  segint_pkg::tag_t            tag_i,
	output logic                        out_vld,
	output logic [segint_pkg::MW-1:0]   m_t,
	output logic [segint_pkg::MW-1:0]   m_u,
	output segint_pkg::tag_t            tag_o
);

	localparam int QW = segint_pkg::QW;
	localparam int MW = segint_pkg::MW;

	logic [QW-1:0]    qin [0:1];
	logic             vld_s [1:MW];
	segint_pkg::tag_t tag_s [1:MW];
	logic [QW-1:0]    rem_s [0:1][1:MW];
	logic [MW-1:0]    m_s   [0:1][1:MW];

	assign qin = '{q_t, q_u};

	for (genvar k = 1; k <= MW; k++) begin : g_ctl
		logic             vld_prev;
		segint_pkg::tag_t tag_prev;

		if (k == 1) begin : g_first
			assign vld_prev = in_vld;
			assign tag_prev = tag_i;
		end else begin : g_next
			assign vld_prev = vld_s[k-1];
			assign tag_prev = tag_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_prev;
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 1; k <= MW; k++) begin : g_bit
			localparam int B = MW - k;
			logic [QW-1:0] rem_prev;
			logic [MW-1:0] m_prev;
			logic [QW-1:0] term;
			logic          ge;

			if (k == 1) begin : g_first
				assign rem_prev = qin[l];
				assign m_prev   = '0;
			end else begin : g_next
				assign rem_prev = rem_s[l][k-1];
				assign m_prev   = m_s[l][k-1];
			end

			// (m + 2^B)^2 - m^2 = m * 2^(B+1) + 2^(2B); m has no bits at or below B.
			assign term = (QW'(m_prev) << (B + 1)) | (QW'(1) << (2 * B));
			assign ge   = rem_prev >= term;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k] <= ge ? rem_prev - term : rem_prev;
					m_s[l][k]   <= m_prev | (MW'(ge) << B);
				end
			end
		end
	end

	assign out_vld = vld_s[MW];
	assign tag_o   = tag_s[MW];
	assign m_t     = m_s[0][MW];
	assign m_u     = m_s[1][MW];

endmodule

// ----- rtl/segment_intersection_test.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_test: fixed-point segment pair intersection test
// Pipeline: a request passes through 6 geometry stages, 64 divider stages,
// 31 root stages and 1 output register before its result is presented.
// Throughput: one request per cycle; the whole pipeline advances whenever the
// output register is empty or being taken. Reset clears all valid bits and
// loads eps_parallel = 1 and eps_param = 0.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       p_x,
	input  logic signed [COORD_WIDTH-1:0]       p_y,
	input  logic signed [COORD_WIDTH-1:0]       p_z,
	input  logic signed [COORD_WIDTH-1:0]       r_x,
	input  logic signed [COORD_WIDTH-1:0]       r_y,
	input  logic signed [COORD_WIDTH-1:0]       r_z,
	input  logic signed [COORD_WIDTH-1:0]       q_x,
	input  logic signed [COORD_WIDTH-1:0]       q_y,
	input  logic signed [COORD_WIDTH-1:0]       q_z,
	input  logic signed [COORD_WIDTH-1:0]       s_x,
	input  logic signed [COORD_WIDTH-1:0]       s_y,
	input  logic signed [COORD_WIDTH-1:0]       s_z,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic                                parallel,
	output logic signed [segint_pkg::OUT_W-1:0] t_param,
	output logic signed [segint_pkg::OUT_W-1:0] u_param,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [segint_pkg::EPSP_W-1:0]       cfg_data
);

	localparam int W     = COORD_WIDTH;
	localparam int NCW   = 4 * W + 2;
	localparam int NVW   = 4 * W + 4;
	localparam int OW    = segint_pkg::OUT_W;
	localparam int MW    = segint_pkg::MW;
	localparam int QW    = segint_pkg::QW;
	localparam int RW    = segint_pkg::OUT_W + 2;

	// Configuration registers. The squared parallel tolerance is kept in a
	// register of its own; the user is to change configuration only while the
	// pipeline is empty (the block itself does not enforce this), so it settles before a request reaches the compare.
	logic [segint_pkg::EPSP_W-1:0] eps_parallel_q;
	logic [segint_pkg::EPS_W-1:0]  eps_param_q;
	logic [segint_pkg::EPSQ_W-1:0] eps_sq_q;

	// Pipeline advance: every stage moves together when the output register
	// can take a new entry, so nothing is lost or repeated under a stall.
	logic en;

	logic signed [W-1:0] p_v [0:2];
	logic signed [W-1:0] r_v [0:2];
	logic signed [W-1:0] q_v [0:2];
	logic signed [W-1:0] s_v [0:2];

	logic             geo_vld;
	logic [NCW-1:0]   geo_nc;
	logic [NVW-1:0]   geo_ntv;
	logic [NVW-1:0]   geo_nuv;
	segint_pkg::tag_t geo_tag;

	logic             div_vld;
	logic [QW-1:0]    div_qt;
	logic [QW-1:0]    div_qu;
	segint_pkg::tag_t div_tag;

	logic             sq_vld;
	logic [MW-1:0]    sq_mt;
	logic [MW-1:0]    sq_mu;
	segint_pkg::tag_t sq_tag;

	logic signed [OW-1:0] t_val;
	logic signed [OW-1:0] u_val;
	logic signed [RW-1:0] t_ext;
	logic signed [RW-1:0] u_ext;
	logic signed [RW-1:0] lo_lim;
	logic signed [RW-1:0] hi_lim;
	logic                 in_range;

	logic                 out_vld_q;
	logic                 hit_q;
	logic                 par_q;
	logic signed [OW-1:0] t_q;
	logic signed [OW-1:0] u_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_parallel_q <= segint_pkg::EPSP_W'(1);
			eps_param_q    <= '0;
			eps_sq_q       <= segint_pkg::EPSQ_W'(1);
		end else begin
			eps_sq_q <= segint_pkg::EPSQ_W'(eps_parallel_q) *
				segint_pkg::EPSQ_W'(eps_parallel_q);
			if (cfg_valid) begin
				unique case (segint_pkg::cfg_idx_t'(cfg_index))
					segint_pkg::CFG_EPS_PARALLEL: begin
						eps_parallel_q <= cfg_data;
					end
					segint_pkg::CFG_EPS_PARAM: begin
						eps_param_q <= cfg_data[segint_pkg::EPS_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	assign p_v = '{p_x, p_y, p_z};
	assign r_v = '{r_x, r_y, r_z};
	assign q_v = '{q_x, q_y, q_z};
	assign s_v = '{s_x, s_y, s_z};

	// Front end: c = r x s, the two cross vectors with d = q - p, their
	// squared norms, dot-product signs and the exact parallel compare.
	segint_geom #(
		.W(W)
	) u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.p       (p_v),
		.r       (r_v),
		.q       (q_v),
		.s       (s_v),
		.eps_sq  (eps_sq_q),
		.out_vld (geo_vld),
		.nc      (geo_nc),
		.ntv     (geo_ntv),
		.nuv     (geo_nuv),
		.tag     (geo_tag)
	);

	// |v|^2 * 2^32 / |c|^2 for both parameters. A parallel request may carry
	// a zero divisor; its quotient is discarded at the output.
	segint_div #(
		.NW(NVW),
		.DW(NCW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (geo_vld),
		.den     (geo_nc),
		.num_t   (geo_ntv),
		.num_u   (geo_nuv),
		.tag_i   (geo_tag),
		.out_vld (div_vld),
		.q_t     (div_qt),
		.q_u     (div_qu),
		.tag_o   (div_tag)
	);

	// The floor of the square root of the truncated quotient equals the
	// truncated exact ratio, and the 31-bit root saturates on its own.
	segint_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.q_t     (div_qt),
		.q_u     (div_qu),
		.tag_i   (div_tag),
		.out_vld (sq_vld),
		.m_t     (sq_mt),
		.m_u     (sq_mu),
		.tag_o   (sq_tag)
	);

	// Apply the sign from the dot product (a zero dot product counts as
	// negative) and force zero on a parallel pair.
	always_comb begin
		t_val = sq_tag.t_pos ? OW'(sq_mt) : -OW'(sq_mt);
		u_val = sq_tag.u_pos ? OW'(sq_mu) : -OW'(sq_mu);
		if (sq_tag.par) begin
			t_val = '0;
			u_val = '0;
		end
	end

	// Range test on the output values: -eps <= v <= 1.0 + eps.
	assign t_ext    = RW'(t_val);
	assign u_ext    = RW'(u_val);
	assign lo_lim   = -$signed(RW'(eps_param_q));
	assign hi_lim   = $signed(RW'(segint_pkg::ONE_Q16)) + $signed(RW'(eps_param_q));
	assign in_range = (t_ext >= lo_lim) && (t_ext <= hi_lim) &&
		(u_ext >= lo_lim) && (u_ext <= hi_lim);

	// Output register: it holds a finished result while the pipeline behind
	// it keeps taking requests as long as the register drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= !sq_tag.par && in_range;
			par_q <= sq_tag.par;
			t_q   <= t_val;
			u_q   <= u_val;
		end
	end

	assign out_valid = out_vld_q;
	assign hit       = hit_q;
	assign parallel  = par_q;
	assign t_param   = t_q;
	assign u_param   = u_q;

	// A parallel pair never reports a hit and carries zero parameters.
	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parallel |-> !hit && (t_param == '0) && (u_param == '0))
		else $error("parallel result with nonzero parameters or hit");

	// Saturation is symmetric, so the most negative code never appears.
	a_sat_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (t_param != {1'b1, {(OW-1){1'b0}}}) &&
			(u_param != {1'b1, {(OW-1){1'b0}}}))
		else $error("parameter took the most negative code");

	// A hit lies inside the tolerance window on both parameters.
	a_hit_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (RW'(t_param) >= lo_lim) && (RW'(t_param) <= hi_lim) &&
			(RW'(u_param) >= lo_lim) && (RW'(u_param) <= hi_lim))
		else $error("hit reported outside the tolerance window");

endmodule
